// File: hdl/dd_pkg.sv
`default_nettype none

package dd_pkg;

    localparam int RESULT_LIMIT = 16;
    localparam int AMOUNT_W = 8;
    localparam int WORK_W = 12;

    localparam logic [1:0] ACT_LOAD_ENTRY = 2'd0;
    localparam logic [1:0] ACT_LOAD_FREE = 2'd1;
    localparam logic [1:0] ACT_RUN = 2'd2;

    localparam logic REG_ACTIVE_PROCESSES = 1'b0;
    localparam logic REG_ACTIVE_RESOURCES = 1'b1;

    localparam logic [4:0] ACTIVE_PROCESSES_RST = 5'd5;
    localparam logic [3:0] ACTIVE_RESOURCES_RST = 4'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] process_index;
        logic [2:0] resource_index;
        logic [7:0] allocation_amount;
        logic [7:0] request_amount;
        logic [7:0] available_amount;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] process_number;
        logic       finished;
        logic       deadlock_found;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [4:0] active_processes;
        logic [3:0] active_resources;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_LOAD_ENTRY,
        CMD_LOAD_FREE,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] process_index;
        logic [2:0] resource_index;
        logic [7:0] allocation_amount;
        logic [7:0] request_amount;
        logic [7:0] available_amount;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PSTART,
        ST_SCAN,
        ST_APPLY,
        ST_PNEXT,
        ST_REPORT
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/dd_ram.sv
`default_nettype none

module dd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/dd_front.sv
`default_nettype none

module dd_front #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dd_pkg::in_beat_t s_data,
    input  wire logic             clear_done,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output dd_pkg::cmd_t          push_cmd
);

    logic keep;
    logic entry_ok;
    logic free_ok;

    assign entry_ok = (32'(s_data.process_index) < MAX_PROCESSES)
                   && (32'(s_data.resource_index) < MAX_RESOURCES);
    assign free_ok = 32'(s_data.resource_index) < MAX_RESOURCES;

    always_comb begin
        push_cmd.process_index = s_data.process_index;
        push_cmd.resource_index = s_data.resource_index;
        push_cmd.allocation_amount = s_data.allocation_amount;
        push_cmd.request_amount = s_data.request_amount;
        push_cmd.available_amount = s_data.available_amount;
        case (s_data.action)
            dd_pkg::ACT_LOAD_ENTRY: begin
                push_cmd.kind = dd_pkg::CMD_LOAD_ENTRY;
                keep = entry_ok;
            end
            dd_pkg::ACT_LOAD_FREE: begin
                push_cmd.kind = dd_pkg::CMD_LOAD_FREE;
                keep = free_ok;
            end
            dd_pkg::ACT_RUN: begin
                push_cmd.kind = dd_pkg::CMD_RUN;
                keep = 1'b1;
            end
            default: begin
                push_cmd.kind = dd_pkg::CMD_RUN;
                keep = 1'b0;
            end
        endcase
    end

    // dropped beats are still taken, they just never reach the queue
    assign s_ready = clear_done && push_ready;
    assign push_valid = s_valid && s_ready && keep;

endmodule

`default_nettype wire

// File: hdl/dd_fifo.sv
`default_nettype none

module dd_fifo (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire dd_pkg::cmd_t push_cmd,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output dd_pkg::cmd_t      pop_cmd
);

    dd_pkg::cmd_t slots_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd = slots_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dd_back.sv
`default_nettype none

module dd_back #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dd_pkg::cfg_t  cfg,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire dd_pkg::cmd_t  pop_cmd,
    output logic               clear_done,
    output logic               m_valid,
    input  wire logic          m_ready,
    output dd_pkg::out_beat_t  m_data
);

    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NP_MAX = MAX_PROCESSES < dd_pkg::RESULT_LIMIT ?
                            MAX_PROCESSES : dd_pkg::RESULT_LIMIT;
    localparam int NP_W = $clog2(NP_MAX + 1);
    localparam int NR_W = $clog2(MAX_RESOURCES + 1);
    localparam int P_W = MAX_PROCESSES > 1 ? $clog2(MAX_PROCESSES) : 1;
    localparam int RI_W = MAX_RESOURCES > 1 ? $clog2(MAX_RESOURCES) : 1;
    localparam int AMT_W = dd_pkg::AMOUNT_W;
    localparam int ENTRY_W = 2 * AMT_W;
    localparam int WK_W = dd_pkg::WORK_W;
    localparam logic [WK_W-1:0] WORK_MAX = {WK_W{1'b1}};
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    dd_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [P_W-1:0]      p_reg, p_next;
    logic [NR_W-1:0]     issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [RI_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                fail_reg, fail_next;
    logic                progress_reg, progress_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [WK_W-1:0]     work_reg [MAX_RESOURCES];
    logic [WK_W-1:0]     work_next [MAX_RESOURCES];
    logic [AMT_W-1:0]    hrow_reg [MAX_RESOURCES];
    logic [AMT_W-1:0]    hrow_next [MAX_RESOURCES];
    logic [AMT_W-1:0]    free_reg [MAX_RESOURCES];
    logic [AMT_W-1:0]    free_next [MAX_RESOURCES];
    logic                out_valid_reg, out_valid_next;
    dd_pkg::out_beat_t   out_beat_reg, out_beat_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [31:0]         np_full;
    logic [31:0]         nr_full;
    logic [NP_W-1:0]     np;
    logic [NR_W-1:0]     nr;
    logic                last_p;
    logic                last_data;
    logic [AMT_W-1:0]    wanted;
    logic [AMT_W-1:0]    held;
    logic                fail_now;
    logic                deadlock;

    dd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        np_full = 32'(cfg.active_processes);
        if (np_full == 32'd0) begin
            np_full = 32'd1;
        end else if (np_full > NP_MAX) begin
            np_full = 32'(NP_MAX);
        end
        nr_full = 32'(cfg.active_resources);
        if (nr_full == 32'd0) begin
            nr_full = 32'd1;
        end else if (nr_full > MAX_RESOURCES) begin
            nr_full = 32'(MAX_RESOURCES);
        end
    end

    assign np = NP_W'(np_full);
    assign nr = NR_W'(nr_full);
    assign last_p = (32'(p_reg) + 32'd1) == 32'(np);
    assign last_data = (32'(pend_idx_reg) + 32'd1) == 32'(nr);
    assign wanted = ram_rdata[AMT_W-1:0];
    assign held = ram_rdata[ENTRY_W-1:AMT_W];
    assign fail_now = WK_W'(wanted) > work_reg[pend_idx_reg];
    assign clear_done = state_reg != dd_pkg::ST_CLEAR;
    assign m_valid = out_valid_reg;
    assign m_data = out_beat_reg;

    always_comb begin
        deadlock = 1'b0;
        for (int i = 0; i < MAX_PROCESSES; i++) begin
            if (i < 32'(np) && !done_reg[i]) begin
                deadlock = 1'b1;
            end
        end
    end

    always_comb begin
        logic [WK_W:0] sum;
        sum = '0;
        state_next = state_reg;
        clr_next = clr_reg;
        p_next = p_reg;
        issue_next = issue_reg;
        pend_next = pend_reg;
        pend_idx_next = pend_idx_reg;
        fail_next = fail_reg;
        progress_next = progress_reg;
        done_next = done_reg;
        work_next = work_reg;
        hrow_next = hrow_reg;
        free_next = free_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_beat_next = out_beat_reg;
        ram_we = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        ram_raddr = AW'(32'(p_reg) * MAX_RESOURCES + 32'(issue_reg));
        pop_ready = 1'b0;

        case (state_reg)
            dd_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_reg == LAST_ADDR) begin
                    state_next = dd_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            dd_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    case (pop_cmd.kind)
                        dd_pkg::CMD_LOAD_ENTRY: begin
                            ram_we = 1'b1;
                            ram_waddr = AW'(32'(pop_cmd.process_index) * MAX_RESOURCES
                                            + 32'(pop_cmd.resource_index));
                            ram_wdata = {pop_cmd.allocation_amount, pop_cmd.request_amount};
                        end
                        dd_pkg::CMD_LOAD_FREE: begin
                            free_next[RI_W'(pop_cmd.resource_index)] =
                                pop_cmd.available_amount;
                        end
                        dd_pkg::CMD_RUN: begin
                            for (int r = 0; r < MAX_RESOURCES; r++) begin
                                work_next[r] = WK_W'(free_reg[r]);
                            end
                            done_next = '0;
                            p_next = '0;
                            progress_next = 1'b0;
                            state_next = dd_pkg::ST_PSTART;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dd_pkg::ST_PSTART: begin
                if (done_reg[p_reg]) begin
                    state_next = dd_pkg::ST_PNEXT;
                end else begin
                    issue_next = '0;
                    pend_next = 1'b0;
                    fail_next = 1'b0;
                    state_next = dd_pkg::ST_SCAN;
                end
            end
            dd_pkg::ST_SCAN: begin
                // read of entry issue_reg overlaps the check of the entry before it
                if (issue_reg < nr) begin
                    pend_next = 1'b1;
                    pend_idx_next = RI_W'(issue_reg);
                    issue_next = issue_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    hrow_next[pend_idx_reg] = held;
                    fail_next = fail_reg || fail_now;
                    if (last_data) begin
                        state_next = (fail_reg || fail_now) ? dd_pkg::ST_PNEXT
                                                           : dd_pkg::ST_APPLY;
                    end
                end
            end
            dd_pkg::ST_APPLY: begin
                for (int r = 0; r < MAX_RESOURCES; r++) begin
                    if (r < 32'(nr)) begin
                        sum = {1'b0, work_reg[r]} + (WK_W + 1)'(hrow_reg[r]);
                        work_next[r] = sum[WK_W] ? WORK_MAX : sum[WK_W-1:0];
                    end
                end
                done_next[p_reg] = 1'b1;
                progress_next = 1'b1;
                state_next = dd_pkg::ST_PNEXT;
            end
            dd_pkg::ST_PNEXT: begin
                if (last_p) begin
                    p_next = '0;
                    progress_next = 1'b0;
                    state_next = progress_reg ? dd_pkg::ST_PSTART : dd_pkg::ST_REPORT;
                end else begin
                    p_next = p_reg + 1'b1;
                    state_next = dd_pkg::ST_PSTART;
                end
            end
            dd_pkg::ST_REPORT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_beat_next.process_number = 4'(p_reg);
                    out_beat_next.finished = done_reg[p_reg];
                    out_beat_next.deadlock_found = deadlock;
                    out_beat_next.last = last_p;
                    if (last_p) begin
                        state_next = dd_pkg::ST_IDLE;
                    end else begin
                        p_next = p_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = dd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dd_pkg::ST_CLEAR;
            clr_reg <= '0;
            p_reg <= '0;
            issue_reg <= '0;
            pend_reg <= 1'b0;
            fail_reg <= 1'b0;
            progress_reg <= 1'b0;
            done_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_RESOURCES; r++) begin
                free_reg[r] <= '0;
            end
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            p_reg <= p_next;
            issue_reg <= issue_next;
            pend_reg <= pend_next;
            fail_reg <= fail_next;
            progress_reg <= progress_next;
            done_reg <= done_next;
            out_valid_reg <= out_valid_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        work_reg <= work_next;
        hrow_reg <= hrow_next;
        out_beat_reg <= out_beat_next;
    end

endmodule

`default_nettype wire

// File: hdl/deadlock_detector.sv
// Resource-allocation deadlock detector.
// Input channel (s_valid/s_ready/s_data): each beat either loads one
// allocation/request pair of a process, loads one available amount, starts
// a detection run, or is dropped (unused action, out-of-range index).
// Loads execute while the back end is idle; a two-entry command queue
// decouples acceptance from execution. A run copies available into the
// work vector and repeats passes over the active processes until a pass
// finishes none. Each unfinished process visited reads one entry-RAM word
// per active resource, pipelined with the check, and adds its allocation
// in a further step when it finishes; a finished one is skipped.
// Passes <= processes + 1. The run then emits one beat per active process
// on m_valid/m_ready/m_data, one per cycle while the receiver is ready,
// last flagged on the final one. Further input waits in the queue during runs.
// A stalled receiver holds the output register; the run waits for it.
// APB registers: 0x0 active_processes, 0x4 active_resources.
// After reset a clearing pass zeroes all MAX_PROCESSES * MAX_RESOURCES
// entry-RAM words (128 by default); s_ready stays low until it ends.
`default_nettype none

module deadlock_detector #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dd_pkg::in_beat_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dd_pkg::out_beat_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    dd_pkg::cfg_t cfg_reg, cfg_next;
    logic         cfg_we;
    logic         clear_done;
    logic         push_valid;
    logic         push_ready;
    dd_pkg::cmd_t push_cmd;
    logic         pop_valid;
    logic         pop_ready;
    dd_pkg::cmd_t pop_cmd;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        prdata = '0;
        case (paddr[2])
            dd_pkg::REG_ACTIVE_PROCESSES: begin
                prdata = 32'(cfg_reg.active_processes);
                if (cfg_we) begin
                    cfg_next.active_processes = pwdata[4:0];
                end
            end
            dd_pkg::REG_ACTIVE_RESOURCES: begin
                prdata = 32'(cfg_reg.active_resources);
                if (cfg_we) begin
                    cfg_next.active_resources = pwdata[3:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_processes <= dd_pkg::ACTIVE_PROCESSES_RST;
            cfg_reg.active_resources <= dd_pkg::ACTIVE_RESOURCES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dd_front #(
        .MAX_PROCESSES(MAX_PROCESSES),
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .clear_done(clear_done),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    dd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd)
    );

    dd_back #(
        .MAX_PROCESSES(MAX_PROCESSES),
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .clear_done(clear_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: hdl/dd_checker.sv
`default_nettype none

module dd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire dd_pkg::out_beat_t m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // an unfinished process means the run found a deadlock
    a_deadlock_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.finished || m_data.deadlock_found))
        else $error("unfinished process without deadlock flag");

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // clearing pass keeps the input closed right after reset
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during clearing pass");

endmodule

bind deadlock_detector dd_checker u_dd_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire

// File: tb/sv/deadlock_detector_tb.sv
`timescale 1ns / 100ps

module deadlock_detector_tb;
    import dd_pkg::*;

    localparam int N_PROCS = 16;
    localparam int N_RES = 8;
    localparam int WORK_MAX = (1 << WORK_W) - 1;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CHUNK_BEATS = 25;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int LIMIT_CYCLES = 3000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    in_beat_t pending_beats[$];
    out_beat_t expected_reports[$];

    logic [AMOUNT_W-1:0] held_amounts [N_PROCS*N_RES] = '{default: '0};
    logic [AMOUNT_W-1:0] wanted_amounts [N_PROCS*N_RES] = '{default: '0};
    logic [AMOUNT_W-1:0] free_amounts [N_RES] = '{default: '0};
    logic [4:0] proc_setting = ACTIVE_PROCESSES_RST;
    logic [3:0] res_setting = ACTIVE_RESOURCES_RST;

    int tx_idle_pct = 29;
    int rx_idle_pct = 84;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int failures = 0;
    int cycle_count = 0;
    int beats_accepted = 0;
    int runs_seen = 0;
    int runs_deadlocked = 0;
    int results_checked = 0;

    deadlock_detector #(
        .MAX_PROCESSES(N_PROCS),
        .MAX_RESOURCES(N_RES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int clamp_count(int v, int hi);
        if (v < 1) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    task automatic predict_beat(input in_beat_t b);
        int p;
        int r;
        int np;
        int nr;
        bit progress;
        bit fit;
        bit any_stuck;
        logic [WORK_W:0] sum;
        logic [WORK_W-1:0] work_units [N_RES];
        bit finish_flags [N_PROCS];
        out_beat_t rep;
        case (b.action)
            ACT_LOAD_ENTRY: begin
                held_amounts[{b.process_index, b.resource_index}] = b.allocation_amount;
                wanted_amounts[{b.process_index, b.resource_index}] = b.request_amount;
            end
            ACT_LOAD_FREE: begin
                free_amounts[b.resource_index] = b.available_amount;
            end
            ACT_RUN: begin
                np = clamp_count(proc_setting, (N_PROCS < RESULT_LIMIT) ? N_PROCS : RESULT_LIMIT);
                nr = clamp_count(res_setting, N_RES);
                for (r = 0; r < N_RES; r++) begin
                    work_units[r] = (r < nr) ? WORK_W'(free_amounts[r]) : '0;
                end
                for (p = 0; p < N_PROCS; p++) begin
                    finish_flags[p] = 1'b0;
                end
                do begin
                    progress = 1'b0;
                    for (p = 0; p < np; p++) begin
                        if (!finish_flags[p]) begin
                            fit = 1'b1;
                            for (r = 0; r < nr; r++) begin
                                if (wanted_amounts[p*N_RES+r] > work_units[r]) begin
                                    fit = 1'b0;
                                end
                            end
                            if (fit) begin
                                for (r = 0; r < nr; r++) begin
                                    sum = work_units[r] + held_amounts[p*N_RES+r];
                                    work_units[r] = (sum > WORK_MAX) ? WORK_W'(WORK_MAX)
                                                                     : sum[WORK_W-1:0];
                                end
                                finish_flags[p] = 1'b1;
                                progress = 1'b1;
                            end
                        end
                    end
                end while (progress);
                any_stuck = 1'b0;
                for (p = 0; p < np; p++) begin
                    if (!finish_flags[p]) begin
                        any_stuck = 1'b1;
                    end
                end
                for (p = 0; p < np; p++) begin
                    rep.process_number = 4'(p);
                    rep.finished = finish_flags[p];
                    rep.deadlock_found = any_stuck;
                    rep.last = (p == np - 1);
                    expected_reports.push_back(rep);
                end
                runs_seen++;
                if (any_stuck) begin
                    runs_deadlocked++;
                end
            end
            default: begin
            end
        endcase
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_beat(s_data);
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_data <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off while input keeps coming
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && pending_beats.size() > 10 && results_checked > 40) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result beat with nothing expected: %p", m_data);
                failures++;
            end else begin
                want = expected_reports.pop_front();
                if (m_data.process_number !== want.process_number) begin
                    $error("process_number: expected %0d, got %0d",
                           want.process_number, m_data.process_number);
                    failures++;
                end
                if (m_data.finished !== want.finished) begin
                    $error("finished: expected %0d, got %0d", want.finished, m_data.finished);
                    failures++;
                end
                if (m_data.deadlock_found !== want.deadlock_found) begin
                    $error("deadlock_found: expected %0d, got %0d",
                           want.deadlock_found, m_data.deadlock_found);
                    failures++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    failures++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic in_beat_t make_beat(logic [1:0] action, logic [3:0] p, logic [2:0] r,
                                           logic [7:0] alloc, logic [7:0] req,
                                           logic [7:0] avail);
        in_beat_t b;
        b.action = action;
        b.process_index = p;
        b.resource_index = r;
        b.allocation_amount = alloc;
        b.request_amount = req;
        b.available_amount = avail;
        return b;
    endfunction

    function automatic logic [7:0] amount_pick(int small_hi);
        return ($urandom_range(99) < 75) ? 8'($urandom_range(small_hi)) : 8'($urandom_range(255));
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t b;
        int k;
        int np;
        int nr;
        np = clamp_count(proc_setting, N_PROCS);
        nr = clamp_count(res_setting, N_RES);
        k = $urandom_range(99);
        if (k < 55) begin
            b.action = ACT_LOAD_ENTRY;
        end else if (k < 72) begin
            b.action = ACT_LOAD_FREE;
        end else if (k < 94) begin
            b.action = ACT_RUN;
        end else begin
            b.action = ACT_UNUSED;
        end
        b.process_index = ($urandom_range(99) < 85) ? 4'($urandom_range(np - 1))
                                                    : 4'($urandom_range(N_PROCS - 1));
        b.resource_index = ($urandom_range(99) < 85) ? 3'($urandom_range(nr - 1))
                                                     : 3'($urandom_range(N_RES - 1));
        b.allocation_amount = amount_pick(10);
        b.request_amount = amount_pick(5);
        b.available_amount = amount_pick(8);
        return b;
    endfunction

    task automatic write_config(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ACTIVE_PROCESSES) begin
            proc_setting = value[4:0];
        end else begin
            res_setting = value[3:0];
        end
    endtask

    // sampled mid-cycle so the sender's updates at the edge are already visible
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_reports.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic settle_block();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int count);
        in_beat_t b;
        int n;
        n = 0;
        while (n < count) begin
            b = random_beat();
            pending_beats.push_back(b);
            if (b.action != ACT_UNUSED) begin
                n++;
            end
        end
    endtask

    initial begin
        int p;
        int m;
        int c;
        int procs;
        int res;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, all stores zero: everyone finishes
        pending_beats.push_back(make_beat(ACT_RUN, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0));
        settle_block();

        write_config(REG_ACTIVE_PROCESSES, 32'd16);
        write_config(REG_ACTIVE_RESOURCES, 32'd8);
        pending_beats.push_back(make_beat(ACT_LOAD_FREE, 4'd0, 3'd1, 8'd0, 8'd0, 8'd255));
        pending_beats.push_back(make_beat(ACT_LOAD_FREE, 4'd15, 3'd7, 8'd255, 8'd255, 8'd0));
        // work on resource 1 saturates
        for (p = 0; p < N_PROCS; p++) begin
            pending_beats.push_back(make_beat(ACT_LOAD_ENTRY, 4'(p), 3'd1, 8'd255, 8'd0, 8'd0));
        end
        pending_beats.push_back(make_beat(ACT_LOAD_ENTRY, 4'd15, 3'd7, 8'd0, 8'd255, 8'd0));
        pending_beats.push_back(make_beat(ACT_UNUSED, 4'($urandom), 3'($urandom),
                                          8'($urandom), 8'($urandom), 8'($urandom)));
        pending_beats.push_back(make_beat(ACT_RUN, 4'd15, 3'd7, 8'd255, 8'd255, 8'd255));
        pending_beats.push_back(make_beat(ACT_LOAD_FREE, 4'd0, 3'd7, 8'd0, 8'd0, 8'd255));
        pending_beats.push_back(make_beat(ACT_RUN, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0));
        settle_block();

        // register values below and above range
        write_config(REG_ACTIVE_PROCESSES, 32'd0);
        write_config(REG_ACTIVE_RESOURCES, 32'd0);
        pending_beats.push_back(make_beat(ACT_RUN, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0));
        settle_block();
        write_config(REG_ACTIVE_PROCESSES, ($urandom & 32'hffff_ffe0) | 32'h1f);
        write_config(REG_ACTIVE_RESOURCES, ($urandom & 32'hffff_fff0) | 32'hf);
        pending_beats.push_back(make_beat(ACT_RUN, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0));
        settle_block();

        for (m = 0; m < 3; m++) begin
            tx_idle_pct = (m == 0) ? 29 : (m == 1) ? 84 : 0;
            rx_idle_pct = (m == 0) ? 84 : (m == 1) ? 29 : 0;
            for (c = 0; c < 3; c++) begin
                if (c == 0) begin
                    procs = $urandom_range(6, 1);
                    res = $urandom_range(4, 1);
                end else if (c == 1) begin
                    procs = $urandom_range(31);
                    res = $urandom_range(15);
                end else if (m == 2) begin
                    procs = N_PROCS;
                    res = N_RES;
                end else begin
                    procs = $urandom_range(10, 1);
                    res = $urandom_range(8, 1);
                end
                settle_block();
                write_config(REG_ACTIVE_PROCESSES, 32'(procs));
                write_config(REG_ACTIVE_RESOURCES, 32'(res));
                queue_random(CHUNK_BEATS / 2);
                if (m == 1 && c == 1) begin
                    wait_drained();
                end
                queue_random(CHUNK_BEATS - CHUNK_BEATS / 2);
            end
        end
        settle_block();

        $display("%0d input beats accepted, %0d detection runs, %0d of them deadlocked",
                 beats_accepted, runs_seen, runs_deadlocked);
        $display("%0d result beats checked across register settings from 1x1 to 16x8",
                 results_checked);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/dd_pkg.sv
hdl/dd_ram.sv
hdl/dd_front.sv
hdl/dd_fifo.sv
hdl/dd_back.sv
hdl/deadlock_detector.sv
hdl/dd_checker.sv
tb/sv/deadlock_detector_tb.sv
